// ----- hdl/chxy_pkg.sv -----
// Shared widths, register indexes, arctangent table and stage type for the compass heading block.
package chxy_pkg;

   localparam int RAW_W            = 16;
   localparam int XY_W             = 17;
   localparam int DP_W             = 44;
   localparam int Z_W              = 22;
   localparam int SCALE_SH         = 24;
   localparam int FRONT_W          = 13;
   localparam int HEAD_W           = 13;
   localparam int WRAP_W           = 15;
   localparam int ROUND_SH         = 8;
   localparam int CORDIC_MAX       = 24;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int LAT_EXTRA        = 4;
   localparam int FULL_TURN        = 5760;
   localparam int HALF_TURN_Z      = 180 * 4096;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_BIAS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_BIAS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONTAL = 2'd2;

   // atan(2^-i) in 1/4096 degree
   localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
      22'd184320, 22'd108810, 22'd57492, 22'd29184, 22'd14649, 22'd7331, 22'd3667, 22'd1833,
      22'd917,    22'd458,    22'd229,   22'd115,   22'd57,    22'd29,   22'd14,   22'd7,
      22'd4,      22'd2,      22'd1,     22'd0,     22'd0,     22'd0,    22'd0,    22'd0
   };

   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic signed [DP_W-1:0] x;
      logic signed [DP_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic signed [XY_W-1:0] cx;
      logic signed [XY_W-1:0] cy;
   } cordic_type;

endpackage

// ----- hdl/compass_heading_from_xy.sv -----
// Top level: compass heading from a magnetometer X/Y sample.
//
// Request: raw_x/raw_y are taken at a rising edge with start high and busy low.
// busy is high only for the cycle after reset; otherwise a new word may be
// given every cycle.
// Response: rsp_valid marks one cycle carrying heading (1/16 degree, 0..5759)
// and the offset-corrected X and Y. Words come out in request order.
// The word passes CORDIC_STEPS + 4 registers: two input/fold stages, one stage
// per CORDIC rotation, two wrap stages. Throughput is one word per cycle, set
// by the fully unrolled rotation chain.
// The receiver cannot stall; there is no backpressure anywhere in the pipe.
// CSR: csr_valid/csr_ready with csr_index (0 X bias, 1 Y bias, 2 frontal
// angle) and csr_wdata; csr_ready is always high, other indexes are dropped.
// Write registers only while no word is in flight.
// Reset (synchronous) zeroes the CSR registers, sets busy and drops every word in flight.
module compass_heading_from_xy
   import chxy_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [RAW_W-1:0] req_raw_x,
   input  logic signed [RAW_W-1:0] req_raw_y,
   output logic                    rsp_valid,
   output logic [HEAD_W-1:0]       rsp_heading,
   output logic signed [XY_W-1:0]  rsp_corrected_x,
   output logic signed [XY_W-1:0]  rsp_corrected_y,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [RAW_W-1:0]        csr_wdata
);

   logic                    busy_ff;
   logic signed [RAW_W-1:0] x_bias_ff, y_bias_ff;
   logic [FRONT_W-1:0]      frontal_ff, frontal_mod_ff, frontal_mod_in;
   logic                    csr_write;
   cordic_type              pipe [CORDIC_STEPS+1];

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         x_bias_ff  <= '0;
         y_bias_ff  <= '0;
         frontal_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_X_BIAS:  x_bias_ff  <= csr_wdata;
               CSR_Y_BIAS:  y_bias_ff  <= csr_wdata;
               CSR_FRONTAL: frontal_ff <= csr_wdata[FRONT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign frontal_mod_in = (frontal_ff >= FRONT_W'(FULL_TURN)) ?
                           frontal_ff - FRONT_W'(FULL_TURN) : frontal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frontal_mod_ff <= '0;
      end else begin
         frontal_mod_ff <= frontal_mod_in;
      end
   end

   chxy_prep u_prep (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy_ff),
      .raw_x  (req_raw_x),
      .raw_y  (req_raw_y),
      .x_bias (x_bias_ff),
      .y_bias (y_bias_ff),
      .st_out (pipe[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      chxy_cordic_stage #(
         .STEP (i)
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .st_in  (pipe[i]),
         .st_out (pipe[i+1])
      );
   end

   chxy_wrap u_wrap (
      .clock           (clock),
      .reset           (reset),
      .st_in           (pipe[CORDIC_STEPS]),
      .frontal_mod     (frontal_mod_ff),
      .rsp_valid       (rsp_valid),
      .rsp_heading     (rsp_heading),
      .rsp_corrected_x (rsp_corrected_x),
      .rsp_corrected_y (rsp_corrected_y)
   );

endmodule

// ----- hdl/chxy_prep.sv -----
// Offset subtraction, half-plane fold and scaling ahead of the CORDIC stages.
module chxy_prep
   import chxy_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic signed [RAW_W-1:0] raw_x,
   input  logic signed [RAW_W-1:0] raw_y,
   input  logic signed [RAW_W-1:0] x_bias,
   input  logic signed [RAW_W-1:0] y_bias,
   output cordic_type              st_out
);

   logic                   valid_ff;
   logic signed [XY_W-1:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [DP_W-1:0] xs, ys;
   logic                   neg;
   cordic_type             st_ff, st_in;

   assign cx_in = $signed({raw_x[RAW_W-1], raw_x}) - $signed({x_bias[RAW_W-1], x_bias});
   assign cy_in = $signed({raw_y[RAW_W-1], raw_y}) - $signed({y_bias[RAW_W-1], y_bias});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   assign xs  = $signed({{(DP_W-XY_W){cx_ff[XY_W-1]}}, cx_ff}) <<< SCALE_SH;
   assign ys  = $signed({{(DP_W-XY_W){cy_ff[XY_W-1]}}, cy_ff}) <<< SCALE_SH;
   assign neg = cx_ff[XY_W-1];

   always_comb begin
      st_in.valid = valid_ff;
      st_in.zero  = (cx_ff == '0) && (cy_ff == '0);
      st_in.cx    = cx_ff;
      st_in.cy    = cy_ff;
      if (neg) begin
         st_in.x = -xs;
         st_in.y = -ys;
         st_in.z = cy_ff[XY_W-1] ? -Z_W'(HALF_TURN_Z) : Z_W'(HALF_TURN_Z);
      end else begin
         st_in.x = xs;
         st_in.y = ys;
         st_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff.valid <= st_in.valid;
      end
      st_ff.zero <= st_in.zero;
      st_ff.x    <= st_in.x;
      st_ff.y    <= st_in.y;
      st_ff.z    <= st_in.z;
      st_ff.cx   <= st_in.cx;
      st_ff.cy   <= st_in.cy;
   end

   assign st_out = st_ff;

endmodule

// ----- hdl/chxy_cordic_stage.sv -----
// One registered vectoring CORDIC micro-rotation.
module chxy_cordic_stage
   import chxy_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  cordic_type st_in,
   output cordic_type st_out
);

   cordic_type             st_ff, nx_in;
   logic signed [DP_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  da;

   assign dx = st_in.y >>> STEP;
   assign dy = st_in.x >>> STEP;
   assign da = $signed(ATAN_TAB[STEP]);

   always_comb begin
      nx_in = st_in;
      if (!st_in.y[DP_W-1]) begin
         nx_in.x = st_in.x + dx;
         nx_in.y = st_in.y - dy;
         nx_in.z = st_in.z + da;
      end else begin
         nx_in.x = st_in.x - dx;
         nx_in.y = st_in.y + dy;
         nx_in.z = st_in.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff.valid <= nx_in.valid;
      end
      st_ff.zero <= nx_in.zero;
      st_ff.x    <= nx_in.x;
      st_ff.y    <= nx_in.y;
      st_ff.z    <= nx_in.z;
      st_ff.cx   <= nx_in.cx;
      st_ff.cy   <= nx_in.cy;
   end

   assign st_out = st_ff;

endmodule

// ----- hdl/chxy_wrap.sv -----
// Rounding to 1/16 degree, frontal subtraction and modulo-360 wrap, two stages.
module chxy_wrap
   import chxy_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cordic_type              st_in,
   input  logic [FRONT_W-1:0]      frontal_mod,
   output logic                    rsp_valid,
   output logic [HEAD_W-1:0]       rsp_heading,
   output logic signed [XY_W-1:0]  rsp_corrected_x,
   output logic signed [XY_W-1:0]  rsp_corrected_y
);

   localparam int A_W = Z_W - ROUND_SH;

   logic signed [Z_W-1:0]    z_eff, z_rnd;
   logic signed [A_W-1:0]    a16;
   logic signed [WRAP_W:0]   u_full;
   logic [WRAP_W-1:0]        u_ff, u_in;
   logic                     valid_ff;
   logic signed [XY_W-1:0]   cx_ff, cy_ff;
   logic [WRAP_W-1:0]        h_wide;
   logic                     out_valid_ff;
   logic [HEAD_W-1:0]        heading_ff, heading_in;
   logic signed [XY_W-1:0]   out_cx_ff, out_cy_ff;

   assign z_eff  = st_in.zero ? '0 : st_in.z;
   assign z_rnd  = z_eff + Z_W'(128);
   assign a16    = z_rnd[Z_W-1:ROUND_SH];
   assign u_full = $signed({{(WRAP_W+1-A_W){a16[A_W-1]}}, a16})
                 - $signed({{(WRAP_W+1-FRONT_W){1'b0}}, frontal_mod})
                 + (WRAP_W+1)'(2 * FULL_TURN);
   assign u_in   = u_full[WRAP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= st_in.valid;
      end
      u_ff  <= u_in;
      cx_ff <= st_in.cx;
      cy_ff <= st_in.cy;
   end

   always_comb begin
      if (u_ff >= WRAP_W'(2 * FULL_TURN)) begin
         h_wide = u_ff - WRAP_W'(2 * FULL_TURN);
      end else if (u_ff >= WRAP_W'(FULL_TURN)) begin
         h_wide = u_ff - WRAP_W'(FULL_TURN);
      end else begin
         h_wide = u_ff;
      end
   end

   assign heading_in = h_wide[HEAD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff;
      end
      heading_ff <= heading_in;
      out_cx_ff  <= cx_ff;
      out_cy_ff  <= cy_ff;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_heading     = heading_ff;
   assign rsp_corrected_x = out_cx_ff;
   assign rsp_corrected_y = out_cy_ff;

endmodule

// ----- hdl/chxy_checker.sv -----
// Port-level checks for the compass heading block, bound to the top level.
module chxy_checker
   import chxy_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [HEAD_W-1:0]       rsp_heading,
   input logic signed [XY_W-1:0]  rsp_corrected_x,
   input logic signed [XY_W-1:0]  rsp_corrected_y
);

   localparam int LAT = CORDIC_STEPS + LAT_EXTRA;

   logic [LAT-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= {acc_ff[LAT-2:0], start && !busy};
      end
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == acc_ff[LAT-1])
      else $error("response strobe does not match request accepted LAT cycles ago");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading < HEAD_W'(FULL_TURN)))
      else $error("heading out of range");

   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_corrected_x != {1'b1, {(XY_W-1){1'b0}}}) &&
                    (rsp_corrected_y != {1'b1, {(XY_W-1){1'b0}}}))
      else $error("corrected value out of range");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind compass_heading_from_xy chxy_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_chxy_checker (.*);
